// ----- hdl/single_linkage_union_find_unit_defines.svh -----
// Assertion macros shared by the union-find unit RTL.
`ifndef SINGLE_LINKAGE_UNION_FIND_UNIT_DEFINES_SVH
`define SINGLE_LINKAGE_UNION_FIND_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SLFU_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("slfu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SLFU_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("slfu: next-cycle check failed");

`endif

// ----- hdl/slfu_pkg.sv -----
// Shared constants, types and helpers of the union-find unit.
package slfu_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int NODE_SLOTS  = 2 * MAX_POINTS;
    localparam int NODE_W      = $clog2(NODE_SLOTS);
    localparam int POINT_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W     = 11;
    localparam int WEIGHT_W    = 26;
    localparam int LOAD_W      = 16;
    localparam int EDGE_W      = 10;
    localparam int OP_W        = 2;
    localparam int NODE_DATA_W = COUNT_W + WEIGHT_W;

    localparam logic [NODE_W-1:0]      POINT_COUNT_RESET = NODE_W'(1024);
    localparam logic [WEIGHT_W-1:0]    ONE_Q8            = WEIGHT_W'(256);
    localparam logic [NODE_DATA_W-1:0] NODE_INIT         = {COUNT_W'(1), ONE_Q8};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MERGE = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_PRESS,
        ST_NODE_A,
        ST_NODE_B,
        ST_LINK_B,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0]   low_root;
        logic [NODE_W-1:0]   high_root;
        logic [COUNT_W-1:0]  member_count;
        logic [WEIGHT_W-1:0] total_weight;
        logic [EDGE_W-1:0]   edge_index;
        logic                error;
    } res_t;

    // Clamp the point count register to the supported range
    function automatic logic [NODE_W-1:0] eff_points(input logic [NODE_W-1:0] pc);
        logic [NODE_W-1:0] n;
        n = pc;
        if (pc < NODE_W'(2))
        begin
            n = NODE_W'(2);
        end
        else if (pc > NODE_W'(MAX_POINTS))
        begin
            n = NODE_W'(MAX_POINTS);
        end
        return n;
    endfunction

endpackage

// ----- hdl/slfu_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read, write-first.
module slfu_ram #(
    parameter int WIDTH = slfu_pkg::NODE_W,
    parameter int DEPTH = slfu_pkg::NODE_SLOTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read with forwarding of a same-cycle write to the same entry
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/slfu_ctrl.sv -----
// Sequencer of the union-find unit: clearing pass, loads, chain walks and merges.
`include "single_linkage_union_find_unit_defines.svh"

module slfu_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [slfu_pkg::NODE_W-1:0]          point_count,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [slfu_pkg::OP_W-1:0]            opcode,
    input  logic [slfu_pkg::POINT_W-1:0]         endpoint_a,
    input  logic [slfu_pkg::POINT_W-1:0]         endpoint_b,
    input  logic [slfu_pkg::LOAD_W-1:0]          weight,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output slfu_pkg::res_t                       res,
    output logic                                 link_we,
    output logic [slfu_pkg::NODE_W-1:0]          link_waddr,
    output logic [slfu_pkg::NODE_W-1:0]          link_wdata,
    output logic [slfu_pkg::NODE_W-1:0]          link_raddr,
    input  logic [slfu_pkg::NODE_W-1:0]          link_rdata,
    output logic                                 node_we,
    output logic [slfu_pkg::NODE_W-1:0]          node_waddr,
    output logic [slfu_pkg::NODE_DATA_W-1:0]     node_wdata,
    output logic [slfu_pkg::NODE_W-1:0]          node_raddr,
    input  logic [slfu_pkg::NODE_DATA_W-1:0]     node_rdata
);

    localparam int NW = slfu_pkg::NODE_W;
    localparam int CW = slfu_pkg::COUNT_W;
    localparam int WW = slfu_pkg::WEIGHT_W;
    localparam int EW = slfu_pkg::EDGE_W;
    localparam int LW = slfu_pkg::LOAD_W;

    slfu_pkg::state_t state_reg, state_next;
    logic [NW-1:0] sweep_reg, sweep_next;
    logic [NW-1:0] steps_reg, steps_next;
    logic [EW-1:0] edges_reg, edges_next;
    logic          second_reg, second_next;

    logic [NW-1:0] node_reg, node_next;
    logic [NW-1:0] walk_reg, walk_next;
    logic [NW-1:0] start_reg, start_next;
    logic [NW-1:0] endb_reg, endb_next;
    logic [NW-1:0] ra_reg, ra_next;
    logic [NW-1:0] rb_reg, rb_next;
    logic [NW-1:0] load_a_reg, load_a_next;
    logic [LW-1:0] load_w_reg, load_w_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [WW-1:0] wt_a_reg, wt_a_next;
    logic [CW-1:0] cnt_sum_reg, cnt_sum_next;
    logic [WW-1:0] wt_sum_reg, wt_sum_next;
    slfu_pkg::res_t res_reg, res_next;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] a_ext;
    logic [NW-1:0] b_ext;
    logic          bad_edge;
    logic [NW-1:0] new_node;
    logic          walk_brk;
    logic [NW-1:0] walk_root;
    logic          last_step;
    logic          press_hit;
    logic [CW:0]   cnt_wide;
    logic [WW:0]   wt_wide;
    logic [CW-1:0] rd_count;
    logic [WW-1:0] rd_weight;
    logic [EW-1:0] edges_inc;
    logic          node_wr_state;
    logic          err_fields_zero;
    logic          roots_in_order;
    logic          in_link_b;

    // Decode operands and helper terms
    assign n_eff     = slfu_pkg::eff_points(point_count);
    assign a_ext     = NW'(endpoint_a);
    assign b_ext     = NW'(endpoint_b);
    assign bad_edge  = (a_ext >= n_eff) || (b_ext >= n_eff)
                       || (NW'(edges_reg) >= (n_eff - NW'(1)));
    assign new_node  = n_eff + NW'(edges_reg);
    assign walk_brk  = (link_rdata == '0) || (link_rdata == node_reg);
    assign walk_root = walk_brk ? node_reg : link_rdata;
    assign last_step = (steps_reg == '1);
    assign press_hit = (link_rdata == node_reg);
    assign rd_count  = node_rdata[slfu_pkg::NODE_DATA_W-1 -: CW];
    assign rd_weight = node_rdata[WW-1:0];
    assign cnt_wide  = {1'b0, cnt_a_reg} + {1'b0, rd_count};
    assign wt_wide   = {1'b0, wt_a_reg} + {1'b0, rd_weight};
    assign edges_inc = edges_reg + EW'(1);
    assign res       = res_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= slfu_pkg::ST_SWEEP;
            sweep_reg  <= '0;
            steps_reg  <= '0;
            edges_reg  <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            steps_reg  <= steps_next;
            edges_reg  <= edges_next;
            second_reg <= second_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        walk_reg    <= walk_next;
        start_reg   <= start_next;
        endb_reg    <= endb_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        load_a_reg  <= load_a_next;
        load_w_reg  <= load_w_next;
        cnt_a_reg   <= cnt_a_next;
        wt_a_reg    <= wt_a_next;
        cnt_sum_reg <= cnt_sum_next;
        wt_sum_reg  <= wt_sum_next;
        res_reg     <= res_next;
    end

    // Next state, memory accesses and handshake
    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        steps_next   = steps_reg;
        edges_next   = edges_reg;
        second_next  = second_reg;
        node_next    = node_reg;
        walk_next    = walk_reg;
        start_next   = start_reg;
        endb_next    = endb_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        load_a_next  = load_a_reg;
        load_w_next  = load_w_reg;
        cnt_a_next   = cnt_a_reg;
        wt_a_next    = wt_a_reg;
        cnt_sum_next = cnt_sum_reg;
        wt_sum_next  = wt_sum_reg;
        res_next     = res_reg;

        link_we    = 1'b0;
        link_waddr = node_reg;
        link_wdata = node_reg;
        link_raddr = node_reg;
        node_we    = 1'b0;
        node_waddr = load_a_reg;
        node_wdata = '0;
        node_raddr = ra_reg;
        item_stall = 1'b1;
        res_valid  = 1'b0;

        unique case (state_reg)
            slfu_pkg::ST_SWEEP:
            begin
                // Reset one entry of each table per cycle
                link_we    = 1'b1;
                link_waddr = sweep_reg;
                link_wdata = '0;
                node_we    = 1'b1;
                node_waddr = sweep_reg;
                node_wdata = (sweep_reg < n_eff) ? slfu_pkg::NODE_INIT : '0;
                sweep_next = sweep_reg + NW'(1);
                if (sweep_reg == '1)
                begin
                    state_next = slfu_pkg::ST_IDLE;
                end
            end

            slfu_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    unique case (opcode)
                        slfu_pkg::OP_CLEAR:
                        begin
                            edges_next = '0;
                            sweep_next = '0;
                            state_next = slfu_pkg::ST_SWEEP;
                        end
                        slfu_pkg::OP_LOAD:
                        begin
                            // Fetch the entry so the count survives the rewrite
                            if (a_ext < n_eff)
                            begin
                                node_raddr  = a_ext;
                                load_a_next = a_ext;
                                load_w_next = weight;
                                state_next  = slfu_pkg::ST_LOAD;
                            end
                        end
                        slfu_pkg::OP_MERGE:
                        begin
                            if (bad_edge)
                            begin
                                res_next       = '0;
                                res_next.error = 1'b1;
                                state_next     = slfu_pkg::ST_EMIT;
                            end
                            else
                            begin
                                link_raddr  = a_ext;
                                node_next   = a_ext;
                                start_next  = a_ext;
                                endb_next   = b_ext;
                                second_next = 1'b0;
                                steps_next  = '0;
                                state_next  = slfu_pkg::ST_WALK;
                            end
                        end
                        default:
                        begin
                            // Reserved code: drop the request
                        end
                    endcase
                end
            end

            slfu_pkg::ST_LOAD:
            begin
                node_we    = 1'b1;
                node_waddr = load_a_reg;
                node_wdata = {rd_count, WW'(load_w_reg)};
                state_next = slfu_pkg::ST_IDLE;
            end

            slfu_pkg::ST_WALK:
            begin
                // Follow the parent chain one link per cycle
                if (walk_brk || last_step)
                begin
                    link_we    = 1'b1;
                    link_waddr = walk_root;
                    link_wdata = walk_root;
                    link_raddr = start_reg;
                    node_next  = walk_root;
                    walk_next  = start_reg;
                    steps_next = '0;
                    state_next = slfu_pkg::ST_PRESS;
                end
                else
                begin
                    node_next  = link_rdata;
                    link_raddr = link_rdata;
                    steps_next = steps_reg + NW'(1);
                end
            end

            slfu_pkg::ST_PRESS:
            begin
                // Point every chain entry straight at the root
                link_raddr = link_rdata;
                if (!press_hit)
                begin
                    link_we    = 1'b1;
                    link_waddr = walk_reg;
                    link_wdata = node_reg;
                    walk_next  = link_rdata;
                    steps_next = steps_reg + NW'(1);
                end
                if (press_hit || last_step)
                begin
                    if (!second_reg)
                    begin
                        ra_next     = node_reg;
                        second_next = 1'b1;
                        start_next  = endb_reg;
                        node_next   = endb_reg;
                        steps_next  = '0;
                        link_raddr  = endb_reg;
                        state_next  = slfu_pkg::ST_WALK;
                    end
                    else
                    begin
                        rb_next    = node_reg;
                        node_raddr = ra_reg;
                        state_next = slfu_pkg::ST_NODE_A;
                    end
                end
            end

            slfu_pkg::ST_NODE_A:
            begin
                cnt_a_next = rd_count;
                wt_a_next  = rd_weight;
                node_raddr = rb_reg;
                state_next = slfu_pkg::ST_NODE_B;
            end

            slfu_pkg::ST_NODE_B:
            begin
                // Saturating sums, then link the first root to the new node
                cnt_sum_next = cnt_wide[CW] ? '1 : cnt_wide[CW-1:0];
                wt_sum_next  = wt_wide[WW] ? '1 : wt_wide[WW-1:0];
                link_we      = 1'b1;
                link_waddr   = ra_reg;
                link_wdata   = new_node;
                state_next   = slfu_pkg::ST_LINK_B;
            end

            slfu_pkg::ST_LINK_B:
            begin
                link_we                = 1'b1;
                link_waddr             = rb_reg;
                link_wdata             = new_node;
                node_we                = 1'b1;
                node_waddr             = new_node;
                node_wdata             = {cnt_sum_reg, wt_sum_reg};
                res_next.low_root      = (ra_reg < rb_reg) ? ra_reg : rb_reg;
                res_next.high_root     = (ra_reg < rb_reg) ? rb_reg : ra_reg;
                res_next.member_count  = cnt_sum_reg;
                res_next.total_weight  = wt_sum_reg;
                res_next.edge_index    = edges_reg;
                res_next.error         = 1'b0;
                edges_next             = edges_inc;
                state_next             = slfu_pkg::ST_EMIT;
            end

            slfu_pkg::ST_EMIT:
            begin
                // Hand the result to the output register
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = slfu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = slfu_pkg::ST_IDLE;
            end
        endcase
    end

    // Terms watched by the checks below
    assign node_wr_state   = (state_reg == slfu_pkg::ST_SWEEP)
                             || (state_reg == slfu_pkg::ST_LOAD)
                             || (state_reg == slfu_pkg::ST_LINK_B);
    assign err_fields_zero = (res.low_root == '0) && (res.high_root == '0)
                             && (res.member_count == '0) && (res.total_weight == '0);
    assign roots_in_order  = (res.low_root <= res.high_root);
    assign in_link_b       = (state_reg == slfu_pkg::ST_LINK_B);

    `SLFU_ASSERT_IMP(a_node_write_states, clk, rst_n, node_we, node_wr_state)
    `SLFU_ASSERT_IMP(a_error_result_clean, clk, rst_n, res_valid && res.error, err_fields_zero)
    `SLFU_ASSERT_IMP(a_roots_ordered, clk, rst_n, res_valid && !res.error, roots_in_order)
    `SLFU_ASSERT_NEXT(a_edge_advance, clk, rst_n, in_link_b, edges_reg == $past(edges_inc))

endmodule

// ----- hdl/single_linkage_union_find_unit.sv -----
// Merge edge: walk and compress the chains of both endpoints, fetch both root entries, then
// link both roots to a new node and emit; the next request is taken once the result enters
// the output register, after any wait while it is full. Each walk and compress pass visits
// one chain entry per cycle. A weight load reads the point's entry, then rewrites its weight;
// reserved codes are dropped, rejected edges emit an error result. Clear and reset sweep all
// 2048 entries of both tables and take no request meanwhile; results wait in an output register.
module single_linkage_union_find_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [slfu_pkg::NODE_W-1:0]         cfg_wdata,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [slfu_pkg::OP_W-1:0]           opcode,
    input  logic [slfu_pkg::POINT_W-1:0]        endpoint_a,
    input  logic [slfu_pkg::POINT_W-1:0]        endpoint_b,
    input  logic [slfu_pkg::LOAD_W-1:0]         weight,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [slfu_pkg::NODE_W-1:0]         low_root,
    output logic [slfu_pkg::NODE_W-1:0]         high_root,
    output logic [slfu_pkg::COUNT_W-1:0]        member_count,
    output logic [slfu_pkg::WEIGHT_W-1:0]       total_weight,
    output logic [slfu_pkg::EDGE_W-1:0]         edge_index,
    output logic                                error
);

    logic [slfu_pkg::NODE_W-1:0]      point_count_reg;
    logic                             out_valid_reg;
    slfu_pkg::res_t                   out_res_reg;

    logic                             res_valid;
    logic                             res_ready;
    slfu_pkg::res_t                   res;

    logic                             link_we;
    logic [slfu_pkg::NODE_W-1:0]      link_waddr;
    logic [slfu_pkg::NODE_W-1:0]      link_wdata;
    logic [slfu_pkg::NODE_W-1:0]      link_raddr;
    logic [slfu_pkg::NODE_W-1:0]      link_rdata;
    logic                             node_we;
    logic [slfu_pkg::NODE_W-1:0]      node_waddr;
    logic [slfu_pkg::NODE_DATA_W-1:0] node_wdata;
    logic [slfu_pkg::NODE_W-1:0]      node_raddr;
    logic [slfu_pkg::NODE_DATA_W-1:0] node_rdata;

    // Hold the point count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= slfu_pkg::POINT_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_wdata;
        end
    end

    // Output register: load a new result when empty or draining
    assign res_ready = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign low_root     = out_res_reg.low_root;
    assign high_root    = out_res_reg.high_root;
    assign member_count = out_res_reg.member_count;
    assign total_weight = out_res_reg.total_weight;
    assign edge_index   = out_res_reg.edge_index;
    assign error        = out_res_reg.error;

    // Parent link table
    slfu_ram #(
        .WIDTH (slfu_pkg::NODE_W),
        .DEPTH (slfu_pkg::NODE_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Member count and summed weight table
    slfu_ram #(
        .WIDTH (slfu_pkg::NODE_DATA_W),
        .DEPTH (slfu_pkg::NODE_SLOTS)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Sequencer
    slfu_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_count (point_count_reg),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .opcode      (opcode),
        .endpoint_a  (endpoint_a),
        .endpoint_b  (endpoint_b),
        .weight      (weight),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_raddr  (link_raddr),
        .link_rdata  (link_rdata),
        .node_we     (node_we),
        .node_waddr  (node_waddr),
        .node_wdata  (node_wdata),
        .node_raddr  (node_raddr),
        .node_rdata  (node_rdata)
    );

endmodule
